// ----- sv/ptmd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptmd_pkg
// Shared types and constants for the paired trimmed-mean block.
// ----------------------------------------------------------------------------
package ptmd_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;
    localparam int DELTA_BITS    = 15;
    localparam int GAIN_BITS     = 17;
    localparam int OFFSET_BITS   = 10;
    localparam int COUNT_BITS    = 7;

    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CALIB_GAIN   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CALIB_OFFSET = 2'd2;

    localparam int TRIM_DIVISOR  = 10;
    localparam int NO_TRIM_LIMIT = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PLACE,
        ST_TRIM,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DIV,
        ST_CAL_MUL,
        ST_CAL_FIN,
        ST_OUT
    } state_t;

endpackage

// ----- sv/ptmd_ram.sv -----
// ----------------------------------------------------------------------------
// ptmd_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ptmd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- sv/ptmd_div.sv -----
// ----------------------------------------------------------------------------
// ptmd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptmd_div #(
    parameter int NUM_BITS = 20,
    parameter int DEN_BITS = 9
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quo
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_BITS-1:0], quo_reg[NUM_BITS-1]};
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ----- sv/paired_trimmed_mean_differential.sv -----
// ----------------------------------------------------------------------------
// paired_trimmed_mean_differential
// Sorted pair store with trimmed-mean, calibrated A-minus-B output.
// ----------------------------------------------------------------------------
// Each accepted pair is insertion-sorted by A into one RAM holding {A,B}.
// Insertion walks down from the top, one RAM read and one write per held pair
// above the insert point. On the pair that completes a measurement the kept
// entries are summed, both sums are divided one after the other by a shared
// bit-serial divider, calibrated, and the result is offered on m_. The next
// pair may be taken while a result waits on m_; a later result holds in the
// calibrate step until the waiting one is taken.
module paired_trimmed_mean_differential #(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [ptmd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ptmd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [SAMPLE_BITS-1:0]               s_sample_a,
    input  logic [SAMPLE_BITS-1:0]               s_sample_b,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ptmd_pkg::DELTA_BITS-1:0] m_delta_mv
);
    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int NW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW  = SAMPLE_BITS + AW;
    localparam int PW    = ptmd_pkg::GAIN_BITS + SAMPLE_BITS;
    localparam int CW    = PW - 16 + 2;
    localparam int CBITS = ptmd_pkg::COUNT_BITS;

    ptmd_pkg::state_t state_reg, state_next;

    logic [CBITS-1:0]                  count_reg;
    logic [ptmd_pkg::GAIN_BITS-1:0]    gain_reg;
    logic [ptmd_pkg::OFFSET_BITS-1:0]  offset_reg;

    logic [NW-1:0]          held_reg, held_next;
    logic [NW-1:0]          pos_reg, pos_next;
    logic [NW-1:0]          idx_reg, idx_next;
    logic [NW-1:0]          hi_reg, hi_next;
    logic [NW-1:0]          valid_reg, valid_next;
    logic [SAMPLE_BITS-1:0] a_reg, a_next, b_reg, b_next;
    logic [SUMW-1:0]        suma_reg, suma_next, sumb_reg, sumb_next;
    logic [SUMW-1:0]        mean_a_reg, mean_a_next;
    logic                   div_b_reg, div_b_next;
    logic [PW-1:0]          prod_a_reg, prod_a_next, prod_b_reg, prod_b_next;
    logic signed [ptmd_pkg::DELTA_BITS-1:0] out_reg, out_next;
    logic                   outv_reg, outv_next;
    logic                   rd_pend_reg, rd_pend_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [2*SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
    logic [SAMPLE_BITS-1:0] rd_a, rd_b;

    logic                   div_start;
    logic [SUMW-1:0]        div_num, div_quo;
    logic                   div_done;

    logic [NW-1:0]          limit;
    logic [NW-1:0]          trim;
    logic [NW-1:0]          n_cur;
    logic [CW-1:0]          cal_a, cal_b;
    logic signed [CW:0]     diff;

    assign rd_a = ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign rd_b = ram_rdata[SAMPLE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= CBITS'(16);
            gain_reg   <= ptmd_pkg::GAIN_BITS'(53000);
            offset_reg <= ptmd_pkg::OFFSET_BITS'(142);
        end else if (cfg_we) begin
            unique case (cfg_index)
                ptmd_pkg::REG_SAMPLE_COUNT: count_reg  <= cfg_data[CBITS-1:0];
                ptmd_pkg::REG_CALIB_GAIN:   gain_reg   <= cfg_data[ptmd_pkg::GAIN_BITS-1:0];
                ptmd_pkg::REG_CALIB_OFFSET:
                    offset_reg <= cfg_data[ptmd_pkg::OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (count_reg == '0) begin
            limit = NW'(1);
        end else if (32'(count_reg) > MAX_SAMPLES) begin
            limit = NW'(MAX_SAMPLES);
        end else begin
            limit = NW'(count_reg);
        end
    end

    // trim = n/10 by reciprocal multiply, exact for n below 1029; at least 1, but 0 for n up to 4
    always_comb begin
        trim = NW'((32'(held_reg) * 205) >> 11);
        if (trim == '0) trim = NW'(1);
        if (32'(held_reg) <= ptmd_pkg::NO_TRIM_LIMIT) trim = '0;
    end

    assign n_cur = held_reg;

    ptmd_ram #(.WIDTH(2*SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    ptmd_div #(.NUM_BITS(SUMW), .DEN_BITS(NW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (valid_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign cal_a = CW'(prod_a_reg >> 16) + CW'(offset_reg);
    assign cal_b = CW'(prod_b_reg >> 16) + CW'(offset_reg);
    assign diff  = $signed({1'b0, cal_a}) - $signed({1'b0, cal_b});

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptmd_pkg::ST_IDLE:
                if (s_valid && s_ready) state_next = (held_reg == '0) ?
                    ptmd_pkg::ST_PLACE : ptmd_pkg::ST_SCAN_RD;
            ptmd_pkg::ST_SCAN_RD:  state_next = ptmd_pkg::ST_SCAN_CHK;
            ptmd_pkg::ST_SCAN_CHK:
                if (rd_a > a_reg && pos_reg > NW'(1)) state_next = ptmd_pkg::ST_SCAN_RD;
                else state_next = ptmd_pkg::ST_PLACE;
            ptmd_pkg::ST_PLACE:
                state_next = (held_reg + 1'b1 >= limit) ? ptmd_pkg::ST_TRIM
                                                        : ptmd_pkg::ST_IDLE;
            ptmd_pkg::ST_TRIM:     state_next = ptmd_pkg::ST_SUM_RD;
            ptmd_pkg::ST_SUM_RD:
                state_next = (idx_reg < hi_reg) ? ptmd_pkg::ST_SUM_ACC
                                                : ptmd_pkg::ST_DIV;
            ptmd_pkg::ST_SUM_ACC:  state_next = ptmd_pkg::ST_SUM_RD;
            ptmd_pkg::ST_DIV:
                if (div_done && div_b_reg) state_next = ptmd_pkg::ST_CAL_MUL;
            ptmd_pkg::ST_CAL_MUL:  state_next = ptmd_pkg::ST_CAL_FIN;
            // hold until the previous result has left
            ptmd_pkg::ST_CAL_FIN:
                if (!outv_reg) state_next = ptmd_pkg::ST_OUT;
            ptmd_pkg::ST_OUT:      state_next = ptmd_pkg::ST_IDLE;
            default:               state_next = ptmd_pkg::ST_IDLE;
        endcase
    end

    // datapath / outputs
    always_comb begin
        held_next    = held_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        hi_next      = hi_reg;
        valid_next   = valid_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        suma_next    = suma_reg;
        sumb_next    = sumb_reg;
        mean_a_next  = mean_a_reg;
        div_b_next   = div_b_reg;
        prod_a_next  = prod_a_reg;
        prod_b_next  = prod_b_reg;
        out_next     = out_reg;
        outv_next    = outv_reg;
        rd_pend_next = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = '0;
        ram_wdata    = {rd_a, rd_b};
        div_start    = 1'b0;
        div_num      = suma_reg;
        if (outv_reg && m_ready) outv_next = 1'b0;
        unique case (state_reg)
            ptmd_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    a_next   = s_sample_a;
                    b_next   = s_sample_b;
                    pos_next = held_reg;
                end
            end
            ptmd_pkg::ST_SCAN_RD: begin
                ram_addr = AW'(pos_reg - 1'b1);
            end
            ptmd_pkg::ST_SCAN_CHK: begin
                if (rd_a > a_reg) begin
                    // shift entry up one place
                    ram_we    = 1'b1;
                    ram_addr  = AW'(pos_reg);
                    ram_wdata = {rd_a, rd_b};
                    pos_next  = pos_reg - 1'b1;
                end
            end
            ptmd_pkg::ST_PLACE: begin
                ram_we    = 1'b1;
                ram_addr  = AW'(pos_reg);
                ram_wdata = {a_reg, b_reg};
                held_next = held_reg + 1'b1;
            end
            ptmd_pkg::ST_TRIM: begin
                idx_next   = trim;
                hi_next    = n_cur - trim;
                valid_next = n_cur - (trim << 1);
                suma_next  = '0;
                sumb_next  = '0;
                held_next  = '0;
            end
            ptmd_pkg::ST_SUM_RD: begin
                ram_addr = AW'(idx_reg);
                if (idx_reg >= hi_reg) begin
                    div_start  = 1'b1;
                    div_num    = suma_reg;
                    div_b_next = 1'b0;
                end
            end
            ptmd_pkg::ST_SUM_ACC: begin
                suma_next = suma_reg + SUMW'(rd_a);
                sumb_next = sumb_reg + SUMW'(rd_b);
                idx_next  = idx_reg + 1'b1;
            end
            ptmd_pkg::ST_DIV: begin
                if (div_done) begin
                    if (!div_b_reg) begin
                        mean_a_next = div_quo;
                        div_start   = 1'b1;
                        div_num     = sumb_reg;
                        div_b_next  = 1'b1;
                    end else begin
                        suma_next = div_quo;
                    end
                end
            end
            ptmd_pkg::ST_CAL_MUL: begin
                prod_a_next = PW'(gain_reg * mean_a_reg[SAMPLE_BITS-1:0]) + PW'(32768);
                prod_b_next = PW'(gain_reg * suma_reg[SAMPLE_BITS-1:0]) + PW'(32768);
            end
            ptmd_pkg::ST_CAL_FIN: begin
                if (!outv_reg) begin
                    if (diff > 16383) out_next = 15'sd16383;
                    else if (diff < -16384) out_next = -15'sd16384;
                    else out_next = diff[ptmd_pkg::DELTA_BITS-1:0];
                end
            end
            ptmd_pkg::ST_OUT: begin
                outv_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign s_ready    = (state_reg == ptmd_pkg::ST_IDLE);
    assign m_valid    = outv_reg;
    assign m_delta_mv = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ptmd_pkg::ST_IDLE;
            held_reg    <= '0;
            outv_reg    <= 1'b0;
            div_b_reg   <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            outv_reg    <= outv_next;
            div_b_reg   <= div_b_next;
            rd_pend_reg <= rd_pend_next;
        end
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        hi_reg     <= hi_next;
        valid_reg  <= valid_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        suma_reg   <= suma_next;
        sumb_reg   <= sumb_next;
        mean_a_reg <= mean_a_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        out_reg    <= out_next;
    end

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(held_reg) <= MAX_SAMPLES)
        else $error("pair count beyond store depth");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ptmd_pkg::ST_IDLE) |-> !s_ready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_delta_mv)))
        else $error("result dropped while stalled");
    a_no_read_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        !rd_pend_reg)
        else $error("unexpected read pending");
endmodule
